// ===== rtl/core/rsc_pkg.sv =====
// Shared types, constants and table builders for the rotation sequence composer.
package rsc_pkg;

	// Field and fixed-point formats
	localparam int ELEM_W       = 32;
	localparam int ANGLE_W      = 32;
	localparam int EFRAC        = ELEM_W - 2;
	localparam int AFRAC        = ANGLE_W - 4;
	localparam int MAX_STEPS    = 48;
	localparam int CORDIC_STEPS = (ELEM_W < MAX_STEPS) ? ELEM_W : MAX_STEPS;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ANG_EXT_W    = ANGLE_W + 2;
	localparam int CW           = 64;
	localparam int SUM_W        = 2 * ELEM_W + 2;
	localparam int AXIS_W       = 2;

	typedef logic signed [ELEM_W-1:0]    elem_t;
	typedef logic signed [ANGLE_W-1:0]   angle_t;
	typedef logic signed [ANG_EXT_W-1:0] angle_ext_t;
	typedef logic signed [CW-1:0]        cw_t;
	typedef logic signed [SUM_W-1:0]     sum_t;
	typedef logic [CORDIC_STEPS-1:0][CW-1:0] atan_tab_t;

	// Axis codes
	typedef enum logic [AXIS_W-1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	// Pi, pi/2 and pi/4 in 62 fraction bits; 1/gain in 60 fraction bits
	localparam logic [63:0] PI_Q62         = 64'hC90FDAA22168C234;
	localparam logic [63:0] HALF_PI_Q62    = 64'h6487ED5110B4611A;
	localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
	localparam cw_t         INV_GAIN_Q60   = 64'sd700114967507363238;

	// Pi and pi/2 rounded to the angle format
	localparam angle_ext_t PI_A =
		ANG_EXT_W'((PI_Q62 + (64'd1 << (61 - AFRAC))) >> (62 - AFRAC));
	localparam angle_ext_t HPI_A =
		ANG_EXT_W'((HALF_PI_Q62 + (64'd1 << (61 - AFRAC))) >> (62 - AFRAC));
	localparam angle_ext_t TWO_PI_A = PI_A <<< 1;

	localparam elem_t ONE_E  = elem_t'(64'd1 << EFRAC);
	localparam elem_t ZERO_E = '0;

	// Saturate a wide signed value to the element range
	function automatic elem_t sat_elem(input sum_t v);
		sum_t hi_lim;
		sum_t lo_lim;
		hi_lim = (sum_t'(1) <<< (ELEM_W - 1)) - sum_t'(1);
		lo_lim = -(sum_t'(1) <<< (ELEM_W - 1));
		if (v > hi_lim) begin
			return elem_t'(hi_lim);
		end else if (v < lo_lim) begin
			return elem_t'(lo_lim);
		end
		return elem_t'(v);
	endfunction

	// Restoring unsigned division, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem    = rem - {1'b0, d};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Arctangent of 2^-i in 61 fraction bits, from the alternating series
	function automatic atan_tab_t build_atan_tab();
		atan_tab_t tab;
		cw_t       sum;
		cw_t       term;
		int        e;
		tab[0] = cw_t'((QUARTER_PI_Q62 + 64'd1) >> 1);
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			sum = '0;
			for (int k = 0; k < 32; k++) begin
				e = 62 - i * (2 * k + 1);
				if (e >= 0) begin
					term = cw_t'(udiv64(64'd1 << e, 64'(2 * k + 1)));
					sum  = k[0] ? (sum - term) : (sum + term);
				end
			end
			tab[i] = (sum + cw_t'(1)) >>> 1;
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan_tab();

	// Control word for one multiply-accumulate operation
	typedef struct packed {
		logic valid;
		logic clr;
		logic sub;
		logic fin;
	} mac_ctl_t;

endpackage

// ===== rtl/core/rsc_cordic.sv =====
// Angle reduction and iterative CORDIC sine/cosine unit.
module rsc_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  rsc_pkg::angle_t       angle,
	output logic                  done,
	output rsc_pkg::elem_t        cos_val,
	output rsc_pkg::elem_t        sin_val
);
	import rsc_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE   = 4'b0001,
		C_REDUCE = 4'b0010,
		C_ITER   = 4'b0100,
		C_FINAL  = 4'b1000
	} cstate_t;

	cstate_t           state_q;
	angle_ext_t        ang_q;
	logic              flip_q;
	cw_t               x_q;
	cw_t               y_q;
	cw_t               z_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	elem_t             cos_q;
	elem_t             sin_q;

	angle_ext_t ang_in;
	angle_ext_t ang_wrap;
	angle_ext_t ang_fold;
	logic       fold;
	cw_t        dx;
	cw_t        dy;
	sum_t       x_rnd;
	sum_t       y_rnd;

	// Wrap the input into [-pi, pi]; one step covers the whole angle range
	always_comb begin
		ang_in = ANG_EXT_W'(angle);
		if (ang_in > PI_A) begin
			ang_wrap = ang_in - TWO_PI_A;
		end else if (ang_in < -PI_A) begin
			ang_wrap = ang_in + TWO_PI_A;
		end else begin
			ang_wrap = ang_in;
		end
	end

	// Fold into [-pi/2, pi/2]; a fold negates both outputs
	always_comb begin
		fold = 1'b1;
		if (ang_q > HPI_A) begin
			ang_fold = ang_q - PI_A;
		end else if (ang_q < -HPI_A) begin
			ang_fold = ang_q + PI_A;
		end else begin
			ang_fold = ang_q;
			fold     = 1'b0;
		end
	end

	// Shifted terms of one rotation step
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	// Round to the element format
	assign x_rnd = (SUM_W'(x_q) + (sum_t'(1) <<< (59 - EFRAC))) >>> (60 - EFRAC);
	assign y_rnd = (SUM_W'(y_q) + (sum_t'(1) <<< (59 - EFRAC))) >>> (60 - EFRAC);

	// Sequence reduction, rotation steps and output rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == C_FINAL);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_REDUCE;
					end
				end
				C_REDUCE: begin
					step_q  <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= C_FINAL;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				C_FINAL: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					ang_q <= ang_wrap;
				end
			end
			C_REDUCE: begin
				flip_q <= fold;
				x_q    <= INV_GAIN_Q60;
				y_q    <= '0;
				z_q    <= CW'(ang_fold) <<< (61 - AFRAC);
			end
			C_ITER: begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ATAN_TAB[step_q];
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ATAN_TAB[step_q];
				end
			end
			C_FINAL: begin
				cos_q <= sat_elem(flip_q ? -x_rnd : x_rnd);
				sin_q <= sat_elem(flip_q ? -y_rnd : y_rnd);
			end
			default: begin
			end
		endcase
	end

	assign done    = done_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

// ===== rtl/core/rsc_mac.sv =====
// Shared signed multiplier with accumulator, rounding and saturation.
module rsc_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  rsc_pkg::mac_ctl_t ctl,
	input  rsc_pkg::elem_t    op_a,
	input  rsc_pkg::elem_t    op_b,
	output logic              res_valid,
	output rsc_pkg::elem_t    res
);
	import rsc_pkg::*;

	mac_ctl_t                    ctl_s1;
	logic signed [2*ELEM_W-1:0]  prod_s1;
	sum_t                        acc_s2;
	logic                        res_valid_s2;
	sum_t                        term;
	sum_t                        acc_base;

	// Stage one: product
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// Signed term and accumulator base for stage two
	assign term     = ctl_s1.sub ? -SUM_W'(prod_s1) : SUM_W'(prod_s1);
	assign acc_base = ctl_s1.clr ? '0 : acc_s2;

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_s2 <= acc_base + term;
		end
	end

	// Control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1       <= '0;
			res_valid_s2 <= 1'b0;
		end else begin
			ctl_s1       <= ctl;
			res_valid_s2 <= ctl_s1.valid & ctl_s1.fin;
		end
	end

	// Round half up and saturate the finished sum
	assign res       = sat_elem((acc_s2 + (sum_t'(1) <<< (EFRAC - 1))) >>> EFRAC);
	assign res_valid = res_valid_s2;

endmodule

// ===== rtl/core/rotation_sequence_compose_core.sv =====
// Top level of the rotation sequence composer: sequencer, matrix and output register.
//
// Input stream (s_*): one word per elementary rotation. s_tdata holds the
// angle in radians (signed Q3.28), s_tuser the axis code (0 x, 1 y, 2 z,
// 3 no rotation), s_tlast marks the final rotation of a sequence.
// Output stream (m_*): one word per sequence, sent after the word marked
// last; m_tdata holds the nine entries of the composed 3x3 matrix, signed
// Q1.30, row-major, entry 00 in the lowest 32 bits.
// Each rotation word holds s_tready low until it is finished, so a new word
// is not taken before the last one is through: a 32-step CORDIC pass for
// cosine and sine, then twelve products through one shared multiplier and
// accumulator. A word with axis code 3 skips both and goes straight to the
// final state. The result is loaded into the output register from the final
// state that follows the last word.
// The output register holds one result; a new sequence runs while it waits.
// If the receiver stalls, a finished sequence waits in the final state until
// the register frees, and no new word is accepted meanwhile.
// Reset empties the output register and loads identity into the matrix.
module rotation_sequence_compose_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rsc_pkg::ANGLE_W-1:0]      s_tdata,  // [31:0] rot_angle
	input  logic [rsc_pkg::AXIS_W-1:0]       s_tuser,  // [1:0] axis_select
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [9*rsc_pkg::ELEM_W-1:0]     m_tdata   // elem_00, 01, 02, 10, ..., 22
);
	import rsc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ROT    = 4'b0010,
		ST_MAC    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	localparam int OPS = 12;

	state_t                   state_q;
	axis_t                    axis_q;
	logic                     last_q;
	logic [3:0]               op_q;
	logic [2:0]               wr_q;
	elem_t                    mat_q [9];
	logic                     m_tvalid_q;
	logic [9*ELEM_W-1:0]      out_q;

	logic                     in_acc;
	logic                     cordic_start;
	logic                     cordic_done;
	elem_t                    cos_v;
	elem_t                    sin_v;
	mac_ctl_t                 mac_ctl;
	elem_t                    op_a;
	elem_t                    op_b;
	logic                     res_valid;
	elem_t                    res;
	logic [1:0]               rd_row;
	logic [1:0]               rd_j;
	logic [3:0]               rd_idx;
	logic [3:0]               wr_idx;
	logic                     out_load;
	logic                     out_free;

	// Column that holds p or q for a given axis
	function automatic logic [1:0] col_of(input axis_t ax, input logic use_q);
		logic [1:0] c;
		case (ax)
			AXIS_X:  c = use_q ? 2'd2 : 2'd1;
			AXIS_Y:  c = use_q ? 2'd0 : 2'd2;
			AXIS_Z:  c = use_q ? 2'd1 : 2'd0;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] idx_of(input logic [1:0] row, input logic [1:0] col);
		return 4'(row) * 4'd3 + 4'(col);
	endfunction

	assign s_tready     = (state_q == ST_IDLE);
	assign in_acc       = s_tvalid & s_tready;
	assign cordic_start = in_acc & (axis_t'(s_tuser) != AXIS_NONE);
	assign out_free     = !m_tvalid_q | m_tready;
	assign out_load     = (state_q == ST_FINISH) & last_q & out_free;

	rsc_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (angle_t'(s_tdata)),
		.done    (cordic_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// Issue order per row: c*p, s*q (new p), c*q, -s*p (new q)
	assign rd_row = op_q[3:2];
	assign rd_j   = op_q[1:0];
	assign rd_idx = idx_of(rd_row, col_of(axis_q, (rd_j == 2'd1) | (rd_j == 2'd2)));
	assign op_a   = ((rd_j == 2'd0) | (rd_j == 2'd2)) ? cos_v : sin_v;
	assign op_b   = mat_q[rd_idx];

	always_comb begin
		mac_ctl.valid = (state_q == ST_MAC) & (op_q < 4'(OPS));
		mac_ctl.clr   = (rd_j == 2'd0) | (rd_j == 2'd2);
		mac_ctl.sub   = (rd_j == 2'd3);
		mac_ctl.fin   = (rd_j == 2'd1) | (rd_j == 2'd3);
	end

	rsc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.op_a      (op_a),
		.op_b      (op_b),
		.res_valid (res_valid),
		.res       (res)
	);

	// Results arrive as new p then new q, row by row
	assign wr_idx = idx_of(wr_q[2:1], col_of(axis_q, wr_q[0]));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
			last_q  <= 1'b0;
			op_q    <= '0;
			wr_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						axis_q  <= axis_t'(s_tuser);
						last_q  <= s_tlast;
						state_q <= cordic_start ? ST_ROT : ST_FINISH;
					end
				end
				ST_ROT: begin
					op_q <= '0;
					wr_q <= '0;
					if (cordic_done) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (mac_ctl.valid) begin
						op_q <= op_q + 4'd1;
					end
					if (res_valid) begin
						wr_q <= wr_q + 3'd1;
						if (wr_q == 3'd5) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (!last_q | out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Accumulated matrix: write back results, reload identity after output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= (i % 4 == 0) ? ONE_E : ZERO_E;
			end
		end else if (out_load) begin
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= (i % 4 == 0) ? ONE_E : ZERO_E;
			end
		end else if (res_valid) begin
			mat_q[wr_idx] <= res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 9; i++) begin
				out_q[i*ELEM_W +: ELEM_W] <= mat_q[i];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// A new result only follows a finished sequence marked last
	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FINISH && last_q))
		else $error("output raised without a finished last word");

	// Matrix holds identity right after a result is loaded
	a_identity_reload: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (mat_q[0] == ONE_E && mat_q[4] == ONE_E && mat_q[1] == ZERO_E))
		else $error("matrix not reloaded with identity");

	// Products only come back while the multiply phase runs
	a_res_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q == ST_MAC))
		else $error("multiplier result outside the multiply phase");

	// Never more than six write-backs per rotation
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= 3'd6)
		else $error("write-back count overrun");

endmodule

// ===== tb/tb_rotation_sequence_compose_core.sv =====
// Self-checking testbench for the rotation sequence composer core.
module tb_rotation_sequence_compose_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rsc_pkg::*;

	// Fixed-point constants of the angle and CORDIC formats
	localparam logic [63:0]        PI_WORD      = 64'hC90FDAA22168C234;
	localparam logic [63:0]        HALF_PI_WORD = 64'h6487ED5110B4611A;
	localparam logic signed [63:0] QPI_WORD     = 64'sh3243F6A8885A308D;
	localparam logic signed [63:0] X_START      = 64'sd700114967507363238;
	localparam int ANG_PI      = int'((PI_WORD + (64'd1 << (61 - AFRAC))) >> (62 - AFRAC));
	localparam int ANG_HALF_PI =
		int'((HALF_PI_WORD + (64'd1 << (61 - AFRAC))) >> (62 - AFRAC));
	localparam int ROT_STEPS   = (ELEM_W < 48) ? ELEM_W : 48;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		axis_t             axis_code;
		logic [ANGLE_W-1:0] angle;
		logic              seq_end;
	} rot_word_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [ANGLE_W-1:0]    s_tdata  = '0;
	logic [AXIS_W-1:0]     s_tuser  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [9*ELEM_W-1:0]   m_tdata;

	rot_word_t                   rot_words [$];
	logic [8:0][ELEM_W-1:0]      expected_matrices [$];
	elem_t                       pose_mat [9];
	logic signed [63:0]          atan_q61 [ROT_STEPS];

	int       total_words   = 0;
	int       words_offered = 0;
	int       words_sent    = 0;
	int       results_seen  = 0;
	int       mismatch_cnt  = 0;
	int       burst_left    = 1;
	int       gap_left      = 0;
	int       rx_mode_left  = 0;
	rx_mode_t rx_mode       = RX_OPEN;
	bit       hold_off      = 1'b0;

	rotation_sequence_compose_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Arctangent of 2^-i from the alternating series, rounded to 61 fraction bits
	function automatic void build_atan_table();
		logic signed [63:0] sum;
		atan_q61[0] = (QPI_WORD + 64'sd1) >>> 1;
		for (int i = 1; i < ROT_STEPS; i++) begin
			sum = '0;
			for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
				if (k % 2 == 1) begin
					sum = sum - (64'sd1 <<< (62 - i * (2 * k + 1))) / (2 * k + 1);
				end else begin
					sum = sum + (64'sd1 <<< (62 - i * (2 * k + 1))) / (2 * k + 1);
				end
			end
			atan_q61[i] = (sum + 64'sd1) >>> 1;
		end
	endfunction

	function automatic void load_identity();
		for (int i = 0; i < 9; i++) begin
			pose_mat[i] = (i % 4 == 0) ? elem_t'(64'sd1 <<< EFRAC) : elem_t'(0);
		end
	endfunction

	function automatic elem_t clip_elem(input logic signed [95:0] v);
		logic signed [95:0] lim;
		lim = 96'sd1 <<< (ELEM_W - 1);
		if (v > lim - 96'sd1) begin
			return elem_t'(lim - 96'sd1);
		end else if (v < -lim) begin
			return elem_t'(-lim);
		end
		return elem_t'(v);
	endfunction

	// Round half up to the element fraction, then saturate
	function automatic elem_t round_elem(input logic signed [95:0] v);
		logic signed [95:0] r;
		r = (v + (96'sd1 <<< (EFRAC - 1))) >>> EFRAC;
		return clip_elem(r);
	endfunction

	// Reduce the angle to +-pi/2, then run the rotation-mode CORDIC
	function automatic void cordic_sincos(input angle_t ang, output elem_t cs, output elem_t sn);
		logic signed [63:0] a, x, y, z, dx, dy, cr, sr;
		bit flip;
		a    = ang;
		flip = 1'b0;
		while (a > ANG_PI) a = a - 2 * ANG_PI;
		while (a < -ANG_PI) a = a + 2 * ANG_PI;
		if (a > ANG_HALF_PI) begin
			a    = a - ANG_PI;
			flip = 1'b1;
		end else if (a < -ANG_HALF_PI) begin
			a    = a + ANG_PI;
			flip = 1'b1;
		end
		z = a <<< (61 - AFRAC);
		x = X_START;
		y = '0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_q61[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_q61[i];
			end
		end
		cr = (x + (64'sd1 <<< (59 - EFRAC))) >>> (60 - EFRAC);
		sr = (y + (64'sd1 <<< (59 - EFRAC))) >>> (60 - EFRAC);
		if (flip) begin
			cr = -cr;
			sr = -sr;
		end
		cs = clip_elem(96'(cr));
		sn = clip_elem(96'(sr));
	endfunction

	// Right-multiply the running matrix by one axis rotation; emit on the last word
	function automatic void compose_word(input axis_t ax, input angle_t ang, input logic fin);
		elem_t                  c, s;
		logic signed [95:0]     cw, sw, pw, qw;
		logic [8:0][ELEM_W-1:0] flat;
		int                     pc, qc;
		if (ax != AXIS_NONE) begin
			case (ax)
				AXIS_X: begin
					pc = 1;
					qc = 2;
				end
				AXIS_Y: begin
					pc = 2;
					qc = 0;
				end
				default: begin
					pc = 0;
					qc = 1;
				end
			endcase
			cordic_sincos(ang, c, s);
			cw = c;
			sw = s;
			for (int r = 0; r < 3; r++) begin
				pw = pose_mat[r * 3 + pc];
				qw = pose_mat[r * 3 + qc];
				pose_mat[r * 3 + pc] = round_elem(cw * pw + sw * qw);
				pose_mat[r * 3 + qc] = round_elem(cw * qw - sw * pw);
			end
		end
		if (fin) begin
			for (int i = 0; i < 9; i++) flat[i] = pose_mat[i];
			expected_matrices.push_back(flat);
			load_identity();
		end
	endfunction

	function automatic void push_word(input axis_t ax, input logic [ANGLE_W-1:0] ang,
		input logic fin);
		rot_word_t w;
		w.axis_code = ax;
		w.angle     = ang;
		w.seq_end   = fin;
		rot_words.push_back(w);
		total_words++;
	endfunction

	// Offer rotation words in bursts with random gaps
	always @(negedge clk) begin : drive_rotations
		rot_word_t w;
		if (arst_n) begin
			if (s_tvalid && words_sent != words_offered) begin
				// hold the word until it is taken
			end else if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (rot_words.size() != 0) begin
				w = rot_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= w.angle;
				s_tuser  <= w.axis_code;
				s_tlast  <= w.seq_end;
				words_offered++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the result side in stretches of its own
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(10, 300);
			end else begin
				rx_mode_left--;
			end
			if (hold_off) begin
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
					default:   m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// Check each matrix word, then predict from each accepted rotation word
	always @(posedge clk) begin : watch_ports
		logic [8:0][ELEM_W-1:0] got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (expected_matrices.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("matrix word with no expectation pending: %h", got);
					end
				end else begin
					want = expected_matrices.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (got[i] !== want[i]) begin
							mismatch_cnt++;
							if (mismatch_cnt <= 10) begin
								$display("matrix mismatch at elem_%0d%0d: expected %h, got %h",
									i / 3, i % 3, want[i], got[i]);
							end
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				words_sent++;
				compose_word(axis_t'(s_tuser), angle_t'(s_tdata), s_tlast);
			end
		end
	end

	// Block the result side for a long stretch so the input backs up
	initial begin : long_stall
		wait (results_seen >= 40);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin : run_limit
		#10ms;
		$display("tb_rotation_sequence_compose_core failed");
		$finish;
	end

	initial begin : stimulus
		int    seq_len;
		int    ang_pick;
		int    ang_base;
		int    ang;
		axis_t ax;
		build_atan_table();
		load_identity();

		// Directed: zero angle, skipped axis, extremes, reduction boundaries
		push_word(AXIS_X, 32'd0, 1'b1);
		push_word(AXIS_NONE, 32'h5A5A_A5A5, 1'b1);
		push_word(AXIS_Y, 32'h7FFF_FFFF, 1'b0);
		push_word(AXIS_Z, 32'h8000_0000, 1'b1);
		push_word(AXIS_X, ANG_PI, 1'b0);
		push_word(AXIS_X, ANG_PI + 1, 1'b0);
		push_word(AXIS_Y, -ANG_PI, 1'b0);
		push_word(AXIS_Y, -ANG_PI - 1, 1'b1);
		push_word(AXIS_Z, ANG_HALF_PI, 1'b0);
		push_word(AXIS_Z, ANG_HALF_PI + 1, 1'b0);
		push_word(AXIS_X, -ANG_HALF_PI, 1'b0);
		push_word(AXIS_X, -ANG_HALF_PI - 1, 1'b1);
		push_word(AXIS_Z, 32'd1, 1'b0);
		push_word(AXIS_Y, 32'hFFFF_FFFF, 1'b0);
		push_word(AXIS_NONE, 32'h1234_5678, 1'b0);
		push_word(AXIS_X, 2 * ANG_PI + 5, 1'b1);
		push_word(AXIS_Z, 2 * ANG_PI, 1'b0);
		push_word(AXIS_Y, -2 * ANG_PI - 3, 1'b0);
		push_word(AXIS_NONE, 32'hFFFF_FFFF, 1'b1);

		// Random sequences, mostly short, some long
		while (total_words < 920) begin
			seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
			for (int n = 0; n < seq_len; n++) begin
				ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE : axis_t'($urandom_range(0, 2));
				ang_pick = $urandom_range(0, 9);
				if (ang_pick < 4) begin
					ang = $urandom();
				end else if (ang_pick < 7) begin
					ang = int'($urandom_range(0, 2 * ANG_PI)) - ANG_PI;
				end else if (ang_pick == 7) begin
					ang = int'($urandom_range(0, 131072)) - 65536;
				end else begin
					case ($urandom_range(0, 7))
						0:       ang_base = ANG_PI;
						1:       ang_base = -ANG_PI;
						2:       ang_base = ANG_HALF_PI;
						3:       ang_base = -ANG_HALF_PI;
						4:       ang_base = 2 * ANG_PI;
						5:       ang_base = -2 * ANG_PI;
						6:       ang_base = 32'h7FFF_FFFF;
						default: ang_base = 32'h8000_0000;
					endcase
					ang = ang_base + int'($urandom_range(0, 8)) - 4;
				end
				push_word(ax, ang, n == seq_len - 1);
			end
		end

		// Release reset away from the active edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all words taken, all matrices back, then settle
		while (words_sent != total_words) @(posedge clk);
		while (expected_matrices.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);

		if (expected_matrices.size() != 0) begin
			$display("%0d matrices never arrived", expected_matrices.size());
		end
		if (mismatch_cnt == 0 && expected_matrices.size() == 0) begin
			$display("tb_rotation_sequence_compose_core passed");
		end else begin
			$display("tb_rotation_sequence_compose_core failed");
		end
		$finish;
	end

endmodule
